// ===== rtl/dcrms_pkg.sv =====
`timescale 1ns / 1ps
// dcrms_pkg: widths, constants and shared types of the DC/RMS meter.
// No dependencies; used by dcrms_engine, the top level and both tb files.
package dcrms_pkg;

    localparam int CODE_W      = 16;   // width of an incoming code
    localparam int COUNT_W     = 16;   // samples per pass
    localparam int GAIN_W      = 3;    // gain exponent
    localparam int OUT_W       = 24;   // microvolt results
    localparam int SUM_W       = 32;   // code sum, wraps
    localparam int FRAC_BITS   = 8;    // Q8 mean and deviation
    localparam int MEAN_W      = SUM_W + FRAC_BITS;
    localparam int ACC_W       = 64;   // square sum and shared adder width
    localparam int DIV_STEPS   = ACC_W;
    localparam int SQRT_STEPS  = ACC_W / 2;
    localparam int STEP_W      = 6;
    localparam int ROOT_W      = ACC_W / 2;
    localparam int SQREM_W     = ROOT_W + 4;
    localparam int DIVREM_W    = COUNT_W + 1;

    localparam logic [CODE_W-1:0] GLITCH_CODE   = 16'd3583;
    localparam logic [OUT_W-1:0]  FULL_SCALE_UV = 24'd10000000;

    typedef struct packed {
        logic [COUNT_W-1:0] sample_count;
        logic [GAIN_W-1:0]  gain_code;
    } cfg_t;

    typedef struct packed {
        logic [OUT_W-1:0] rms_microvolts;
        logic [OUT_W-1:0] dc_microvolts;
    } result_t;

endpackage

// ===== rtl/dcrms_engine.sv =====
`timescale 1ns / 1ps
// dcrms_engine: sequencer around one shared 64-bit adder/subtractor that does
// accumulation, shift-add multiply, restoring divide and square root.
// Depends on dcrms_pkg.
module dcrms_engine #(
    parameter int CODE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [dcrms_pkg::CODE_W-1:0]  sample_code,
    input  dcrms_pkg::cfg_t               cfg,
    output logic                          ready,
    output logic                          res_valid,
    input  logic                          res_ready,
    output dcrms_pkg::result_t            res
);

    localparam int MASK_BITS  = (CODE_BITS < dcrms_pkg::CODE_W) ? CODE_BITS
                                                                : dcrms_pkg::CODE_W;
    localparam logic [dcrms_pkg::CODE_W-1:0] CODE_MASK =
        dcrms_pkg::CODE_W'((33'd1 << MASK_BITS) - 33'd1);
    localparam int SHIFT_BASE = dcrms_pkg::FRAC_BITS + CODE_BITS;
    localparam int AW = dcrms_pkg::ACC_W;
    localparam int MW = dcrms_pkg::MEAN_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ACC, ST_DEV1, ST_DEV2, ST_MUL, ST_DIV, ST_SQRT, ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        JOB_MEAN, JOB_SQUARE, JOB_VAR, JOB_SCALE_DC, JOB_SCALE_RMS
    } job_t;

    // architectural state
    state_t                         state_reg,  state_next;
    logic                           phase_reg,  phase_next;
    logic [dcrms_pkg::COUNT_W-1:0]  seen_reg,   seen_next;
    logic [dcrms_pkg::SUM_W-1:0]    sum_reg,    sum_next;
    logic [MW-1:0]                  mean_reg,   mean_next;
    logic [AW-1:0]                  sq_reg,     sq_next;

    // working registers
    job_t                           job_reg,    job_next;
    logic                           close_reg,  close_next;
    logic [dcrms_pkg::CODE_W-1:0]   code_reg,   code_next;
    logic [dcrms_pkg::COUNT_W-1:0]  n_reg,      n_next;
    logic [dcrms_pkg::GAIN_W-1:0]   gain_reg,   gain_next;
    logic [AW-1:0]                  acc_reg,    acc_next;
    logic [AW-1:0]                  mcand_reg,  mcand_next;
    logic [MW-1:0]                  mplier_reg, mplier_next;
    logic [dcrms_pkg::SQREM_W-1:0]  rem_reg,    rem_next;
    logic [dcrms_pkg::ROOT_W-1:0]   root_reg,   root_next;
    logic [dcrms_pkg::STEP_W-1:0]   step_reg,   step_next;
    logic [dcrms_pkg::OUT_W-1:0]    dc_reg,     dc_next;
    logic [dcrms_pkg::OUT_W-1:0]    rms_reg,    rms_next;

    // shared unit
    logic [AW-1:0] add_a, add_b, add_s;
    logic          add_sub, add_c;

    assign {add_c, add_s} = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                          + (AW+1)'(add_sub);

    assign ready     = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_EMIT);
    assign res.dc_microvolts  = dc_reg;
    assign res.rms_microvolts = rms_reg;

    always_comb
    begin
        logic [dcrms_pkg::CODE_W-1:0]   code_m;
        logic [dcrms_pkg::COUNT_W-1:0]  n_eff;
        logic [dcrms_pkg::COUNT_W-1:0]  seen_inc;
        logic [dcrms_pkg::DIVREM_W-1:0] drem_sh;
        logic [dcrms_pkg::SQREM_W-1:0]  srem_sh;
        logic [AW-1:0]                  div_q;
        logic [dcrms_pkg::ROOT_W-1:0]   root_fin;
        logic [AW-1:0]                  scaled;

        code_m   = sample_code & CODE_MASK;
        n_eff    = (cfg.sample_count == '0) ? dcrms_pkg::COUNT_W'(1) : cfg.sample_count;
        seen_inc = seen_reg + dcrms_pkg::COUNT_W'(1);
        drem_sh  = {rem_reg[dcrms_pkg::COUNT_W-1:0], acc_reg[AW-1]};
        srem_sh  = {rem_reg[dcrms_pkg::SQREM_W-3:0], acc_reg[AW-1:AW-2]};
        div_q    = {acc_reg[AW-2:0], add_c};
        root_fin = {root_reg[dcrms_pkg::ROOT_W-2:0], add_c};
        scaled   = (acc_reg >> SHIFT_BASE) >> gain_reg;

        state_next  = state_reg;
        phase_next  = phase_reg;
        seen_next   = seen_reg;
        sum_next    = sum_reg;
        mean_next   = mean_reg;
        sq_next     = sq_reg;
        job_next    = job_reg;
        close_next  = close_reg;
        code_next   = code_reg;
        n_next      = n_reg;
        gain_next   = gain_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        step_next   = step_reg;
        dc_next     = dc_reg;
        rms_next    = rms_reg;

        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start && (code_m != dcrms_pkg::GLITCH_CODE))
                begin
                    code_next  = code_m;
                    n_next     = n_eff;
                    gain_next  = cfg.gain_code;
                    seen_next  = seen_inc;
                    close_next = (seen_inc >= n_eff);
                    state_next = phase_reg ? ST_DEV1 : ST_ACC;
                end
            end

            ST_ACC:
            begin
                add_a    = AW'(sum_reg);
                add_b    = AW'(code_reg);
                sum_next = add_s[dcrms_pkg::SUM_W-1:0];
                if (close_reg)
                begin
                    acc_next   = AW'({add_s[dcrms_pkg::SUM_W-1:0],
                                      dcrms_pkg::FRAC_BITS'(0)});
                    rem_next   = '0;
                    step_next  = '0;
                    job_next   = JOB_MEAN;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            // |x - mean|: try x - mean first, swap on borrow
            ST_DEV1:
            begin
                add_a   = AW'({code_reg, dcrms_pkg::FRAC_BITS'(0)});
                add_b   = AW'(mean_reg);
                add_sub = 1'b1;
                if (add_c)
                begin
                    acc_next    = sq_reg;
                    mcand_next  = AW'(add_s[MW-1:0]);
                    mplier_next = add_s[MW-1:0];
                    job_next    = JOB_SQUARE;
                    state_next  = ST_MUL;
                end
                else
                begin
                    state_next = ST_DEV2;
                end
            end

            ST_DEV2:
            begin
                add_a       = AW'(mean_reg);
                add_b       = AW'({code_reg, dcrms_pkg::FRAC_BITS'(0)});
                add_sub     = 1'b1;
                acc_next    = sq_reg;
                mcand_next  = AW'(add_s[MW-1:0]);
                mplier_next = add_s[MW-1:0];
                job_next    = JOB_SQUARE;
                state_next  = ST_MUL;
            end

            // shift-add multiply into acc, ends when the multiplier runs out
            ST_MUL:
            begin
                add_a = acc_reg;
                add_b = mplier_reg[0] ? mcand_reg : '0;
                if (mplier_reg == '0)
                begin
                    case (job_reg)
                        JOB_SQUARE:
                        begin
                            sq_next = acc_reg;
                            if (close_reg)
                            begin
                                rem_next   = '0;
                                step_next  = '0;
                                job_next   = JOB_VAR;
                                state_next = ST_DIV;
                            end
                            else
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                        JOB_SCALE_DC:
                        begin
                            dc_next     = scaled[dcrms_pkg::OUT_W-1:0];
                            acc_next    = '0;
                            mcand_next  = AW'(root_reg);
                            mplier_next = MW'(dcrms_pkg::FULL_SCALE_UV);
                            job_next    = JOB_SCALE_RMS;
                        end
                        default:
                        begin
                            rms_next   = scaled[dcrms_pkg::OUT_W-1:0];
                            state_next = ST_EMIT;
                        end
                    endcase
                end
                else
                begin
                    acc_next    = add_s;
                    mcand_next  = {mcand_reg[AW-2:0], 1'b0};
                    mplier_next = {1'b0, mplier_reg[MW-1:1]};
                end
            end

            // restoring divide by n, one quotient bit per cycle
            ST_DIV:
            begin
                add_a     = AW'(drem_sh);
                add_b     = AW'(n_reg);
                add_sub   = 1'b1;
                rem_next  = dcrms_pkg::SQREM_W'(add_c ? add_s[dcrms_pkg::DIVREM_W-1:0]
                                                      : drem_sh);
                acc_next  = div_q;
                step_next = step_reg + dcrms_pkg::STEP_W'(1);
                if (step_reg == dcrms_pkg::STEP_W'(dcrms_pkg::DIV_STEPS - 1))
                begin
                    if (job_reg == JOB_MEAN)
                    begin
                        mean_next  = div_q[MW-1:0];
                        sum_next   = '0;
                        seen_next  = '0;
                        phase_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rem_next   = '0;
                        root_next  = '0;
                        step_next  = '0;
                        state_next = ST_SQRT;
                    end
                end
            end

            // digit-by-digit square root, two radicand bits per cycle
            ST_SQRT:
            begin
                add_a     = AW'(srem_sh);
                add_b     = AW'({root_reg, 2'b01});
                add_sub   = 1'b1;
                rem_next  = add_c ? add_s[dcrms_pkg::SQREM_W-1:0] : srem_sh;
                root_next = root_fin;
                acc_next  = {acc_reg[AW-3:0], 2'b00};
                step_next = step_reg + dcrms_pkg::STEP_W'(1);
                if (step_reg == dcrms_pkg::STEP_W'(dcrms_pkg::SQRT_STEPS - 1))
                begin
                    acc_next    = '0;
                    mcand_next  = AW'(mean_reg);
                    mplier_next = MW'(dcrms_pkg::FULL_SCALE_UV);
                    job_next    = JOB_SCALE_DC;
                    state_next  = ST_MUL;
                end
            end

            ST_EMIT:
            begin
                if (res_ready)
                begin
                    phase_next = 1'b0;
                    seen_next  = '0;
                    sum_next   = '0;
                    mean_next  = '0;
                    sq_next    = '0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= 1'b0;
            seen_reg  <= '0;
            sum_reg   <= '0;
            mean_reg  <= '0;
            sq_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            seen_reg  <= seen_next;
            sum_reg   <= sum_next;
            mean_reg  <= mean_next;
            sq_reg    <= sq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        close_reg  <= close_next;
        code_reg   <= code_next;
        n_reg      <= n_next;
        gain_reg   <= gain_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        step_reg   <= step_next;
        dc_reg     <= dc_next;
        rms_reg    <= rms_next;
    end

endmodule

// ===== rtl/two_pass_dc_and_rms_meter_unit.sv =====
`timescale 1ns / 1ps
// two_pass_dc_and_rms_meter_unit: top level with APB registers, the input
// stream, and the output register. Depends on dcrms_pkg and dcrms_engine.
//
// Usage
//   s_axis carries raw unipolar ADC codes. The first sample_count accepted
//   codes form the DC mean (Q8), the next sample_count codes are squared
//   deviations from it. The sample closing the second pass yields one m_axis
//   transaction: DC level and RMS, both in microvolts, full scale
//   10 V / 2^gain_code. Code 3583 is a glitch: accepted, dropped, not counted.
// Sequence (per accepted sample, all through one shared 64-bit adder)
//   mean pass       : accumulate; the closing sample adds a 64-step divide
//   deviation pass  : shift-add square of the deviation (one multiplier bit per cycle)
//   closing sample  : square, 64-step divide, 32-step square root, then
//                     shift-add scalings of DC and RMS, then the result
//   s_axis_tready is high only while the sequencer is idle.
// Stalls
//   m_axis has an output register: samples of the next measurement
//   are taken while a result waits; only a further result stalls the
//   sequencer until the register empties.
// Reset
//   rst_n (async) clears the measurement, sample_count to 1, gain_code to 0.
//   sample_count 0 behaves as 1. Write registers only while the block is idle.

module two_pass_dc_and_rms_meter_unit #(
    parameter int CODE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample_code
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // [23:0] dc_microvolts, [47:24] rms_microvolts
);

    // register index is paddr[2]: 0 sample_count, 1 gain_code
    localparam logic REG_SAMPLE_COUNT = 1'b0;
    localparam logic REG_GAIN_CODE    = 1'b1;

    logic [dcrms_pkg::COUNT_W-1:0] count_reg;
    logic [dcrms_pkg::GAIN_W-1:0]  gain_reg;
    logic                          m_valid_reg;
    dcrms_pkg::result_t            m_data_reg;

    dcrms_pkg::cfg_t    cfg;
    dcrms_pkg::result_t res;
    logic               eng_ready, res_valid, res_ready, wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            REG_SAMPLE_COUNT: prdata = 32'(count_reg);
            REG_GAIN_CODE:    prdata = 32'(gain_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= dcrms_pkg::COUNT_W'(1);
            gain_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_SAMPLE_COUNT: count_reg <= pwdata[dcrms_pkg::COUNT_W-1:0];
                REG_GAIN_CODE:    gain_reg  <= pwdata[dcrms_pkg::GAIN_W-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg.sample_count = count_reg;
    assign cfg.gain_code    = gain_reg;

    assign s_axis_tready = eng_ready;

    dcrms_engine #(
        .CODE_BITS (CODE_BITS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (s_axis_tvalid && eng_ready),
        .sample_code (s_axis_tdata),
        .cfg         (cfg),
        .ready       (eng_ready),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // output register: takes a new result when empty or being drained
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_data_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ===== tb/two_pass_dc_and_rms_meter_checker.sv =====
`timescale 1ns / 1ps
// two_pass_dc_and_rms_meter_checker: watches the APB port and both streams of
// the DC/RMS meter, predicts each reading and compares it. Depends on dcrms_pkg.
module two_pass_dc_and_rms_meter_checker
    import dcrms_pkg::*;
#(
    parameter logic [2:0] COUNT_ADDR = 3'd0,
    parameter logic [2:0] GAIN_ADDR  = 3'd4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample_code
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,   // [23:0] dc_microvolts, [47:24] rms_microvolts
    output int          errors,
    output int          readings_due
);

    // shadow of the block's registers and measurement state
    logic [COUNT_W-1:0] count_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic               in_deviation_pass;
    logic [COUNT_W-1:0] pass_samples;
    logic [SUM_W-1:0]   code_total;
    logic [63:0]        mean_q8;
    logic [63:0]        square_total_q16;

    result_t expected_readings[$];
    int      fail_count;

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        $display("[%0t] reading: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // Q8 code units to microvolts, full scale 10 V / 2^gain
    function automatic logic [OUT_W-1:0] q8_to_microvolts(input logic [63:0] q8,
                                                          input logic [GAIN_W-1:0] g);
        logic [63:0] scaled;
        scaled = (q8 * 64'(FULL_SCALE_UV)) >> (FRAC_BITS + CODE_W + g);
        return scaled[OUT_W-1:0];
    endfunction

    task automatic absorb_sample(input logic [CODE_W-1:0] code);
        logic [63:0] n;
        logic [63:0] x;
        logic [63:0] dev;
        result_t     reading;
        n = (count_reg == '0) ? 64'd1 : 64'(count_reg);
        if (code == GLITCH_CODE)
            return;
        pass_samples = pass_samples + 1'b1;
        if (!in_deviation_pass)
        begin
            code_total = code_total + SUM_W'(code);
            if (64'(pass_samples) >= n)
            begin
                mean_q8           = (64'(code_total) << FRAC_BITS) / n;
                code_total        = '0;
                pass_samples      = '0;
                in_deviation_pass = 1'b1;
            end
            return;
        end
        x   = 64'(code) << FRAC_BITS;
        dev = (x >= mean_q8) ? x - mean_q8 : mean_q8 - x;
        square_total_q16 = square_total_q16 + dev * dev;
        if (64'(pass_samples) >= n)
        begin
            reading.dc_microvolts  = q8_to_microvolts(mean_q8, gain_reg);
            reading.rms_microvolts = q8_to_microvolts(floor_sqrt(square_total_q16 / n),
                                                      gain_reg);
            expected_readings.push_back(reading);
            in_deviation_pass = 1'b0;
            pass_samples      = '0;
            code_total        = '0;
            mean_q8           = '0;
            square_total_q16  = '0;
        end
    endtask

    task automatic check_reading(input result_t got);
        result_t want;
        if (expected_readings.size() == 0)
        begin
            report_mismatch("unexpected transaction", 48'(got), '0);
            return;
        end
        want = expected_readings.pop_front();
        if (got.dc_microvolts !== want.dc_microvolts)
            report_mismatch("dc_microvolts", 48'(got.dc_microvolts), 48'(want.dc_microvolts));
        if (got.rms_microvolts !== want.rms_microvolts)
            report_mismatch("rms_microvolts", 48'(got.rms_microvolts),
                            48'(want.rms_microvolts));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg         = COUNT_W'(1);
            gain_reg          = '0;
            in_deviation_pass = 1'b0;
            pass_samples      = '0;
            code_total        = '0;
            mean_q8           = '0;
            square_total_q16  = '0;
            expected_readings.delete();
            fail_count        = 0;
            errors           <= 0;
            readings_due     <= 0;
        end
        else
        begin
            // a reading leaving now was predicted before any sample taken now
            if (m_axis_tvalid && m_axis_tready)
                check_reading(m_axis_tdata);
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == COUNT_ADDR)
                    count_reg = pwdata[COUNT_W-1:0];
                else if (paddr == GAIN_ADDR)
                    gain_reg = pwdata[GAIN_W-1:0];
            end
            if (s_axis_tvalid && s_axis_tready)
                absorb_sample(s_axis_tdata);
            errors       <= fail_count;
            readings_due <= expected_readings.size();
        end
    end

endmodule

// ===== tb/two_pass_dc_and_rms_meter_unit_tb.sv =====
`timescale 1ns / 1ps
// two_pass_dc_and_rms_meter_unit_tb: stimulus and verdict for the DC/RMS meter.
// Depends on dcrms_pkg, two_pass_dc_and_rms_meter_unit and the checker module.
module two_pass_dc_and_rms_meter_unit_tb;
    import dcrms_pkg::*;

    // register map: one 32-bit register per word
    localparam logic [2:0] ADDR_SAMPLE_COUNT = 3'd0;
    localparam logic [2:0] ADDR_GAIN_CODE    = 3'd4;

    localparam int RANDOM_SAMPLES = 1530;
    // settle margin: room for a closing sample's work plus an output stall
    localparam int SETTLE_CYCLES  = 300;
    localparam int HOLD_CYCLES    = 3000;
    // watchdog limit: room for the slowest run with gaps, stalls, the hold and settles
    localparam int CYCLE_LIMIT    = 3000000;

    typedef enum int {
        WAVE_FULL,      // any code
        WAVE_NOISY,     // base with low bits toggling
        WAVE_FLAT,      // constant: zero RMS
        WAVE_RAILS      // 0 / full scale: largest deviations
    } wave_shape_e;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // [15:0] sample_code
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // [23:0] dc_microvolts, [47:24] rms_microvolts

    int          errors;
    int          readings_due;
    int unsigned cycle_count   = 0;
    bit          sender_gaps_on = 1'b1;
    bit          hold_request   = 1'b0;
    bit          hold_done      = 1'b0;

    two_pass_dc_and_rms_meter_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    two_pass_dc_and_rms_meter_checker #(
        .COUNT_ADDR (ADDR_SAMPLE_COUNT),
        .GAIN_ADDR  (ADDR_GAIN_CODE)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .errors        (errors),
        .readings_due  (readings_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog: a hang or a lost reading ends here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("two_pass_dc_and_rms_meter_unit: mismatch");
            $finish;
        end
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [15:0] pick_code(input wave_shape_e shape,
                                              input logic [15:0] base);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return GLITCH_CODE;
        case (shape)
            WAVE_FULL:  return 16'($urandom);
            WAVE_NOISY: return base ^ 16'($urandom_range(0, 31));
            WAVE_FLAT:  return base;
            default:    return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    // setup cycle, then access cycle; the register takes the write when pready is high
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // offer one sample and hold it until the block takes it
    task automatic send_sample(input logic [15:0] code);
        int gap;
        gap = sender_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Block idle: every predicted reading taken, then room for a closing
    // divide/sqrt or a mean-pass divide that yields nothing.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (readings_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [15:0] count, input logic [2:0] gain);
        wait_idle();
        apb_write(ADDR_SAMPLE_COUNT, 32'(count));
        // bus idle between transfers
        @(posedge clk);
        apb_write(ADDR_GAIN_CODE, 32'(gain));
    endtask

    // Result side: random stalls and runs; once, a long hold so the output
    // register fills, the sequencer blocks and s_axis_tready drops.
    initial
    begin
        int stall;
        int run;
        @(posedge rst_n);
        forever
        begin
            if (hold_request && !hold_done)
            begin
                stall     = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            else
                stall = pick_gap();
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                              : $urandom_range(1, 8);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat (run) @(posedge clk);
        end
    end

    initial
    begin
        int          sent;
        int          phase_len;
        logic [15:0] code;
        logic [15:0] base;
        logic [15:0] count;
        wave_shape_e shape;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---
        // reset config (N = 1, gain 1x): rail to rail, largest RMS
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        // glitch code ignored, then mean at full scale
        send_sample(GLITCH_CODE);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        // count of zero acts as one; top gain; flat input gives zero RMS
        configure(16'd0, 3'd7);
        send_sample(16'hFFFF);
        send_sample(16'hFFFF);
        // count lowered during the mean pass: closes on the next sample, divisor 2
        configure(16'hFFFF, 3'd3);
        send_sample(16'd100);
        send_sample(16'd200);
        send_sample(16'd300);
        configure(16'd2, 3'd3);
        send_sample(16'd400);
        send_sample(GLITCH_CODE);
        send_sample(16'd1);
        send_sample(16'd2);
        // count lowered during the deviation pass, gain changed before the close
        configure(16'd1, 3'd0);
        send_sample(16'd12345);
        configure(16'hFFFF, 3'd5);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h1234);
        configure(16'd2, 3'd1);
        send_sample(16'hAAAA);

        // --- pressure: N = 1, no sender gaps, receiver holds off ---
        configure(16'd1, 3'd2);
        sender_gaps_on = 1'b0;
        hold_request   = 1'b1;
        sent = 0;
        while (sent < 60)
        begin
            code = pick_code(WAVE_FULL, '0);
            send_sample(code);
            if (code != GLITCH_CODE)
                sent++;
        end
        sender_gaps_on = 1'b1;

        // --- random phases: new config between phases, measurements span them ---
        while (sent < RANDOM_SAMPLES)
        begin
            case ($urandom_range(0, 9))
                0:       count = 16'd1;
                1:       count = 16'd0;
                2:       count = 16'($urandom_range(20, 64));
                default: count = 16'($urandom_range(2, 8));
            endcase
            configure(count, 3'($urandom_range(0, 7)));
            sender_gaps_on = ($urandom_range(0, 4) != 0);
            shape = wave_shape_e'($urandom_range(0, 3));
            base  = 16'($urandom);
            if (base == GLITCH_CODE)
                base = base + 1'b1;
            phase_len = $urandom_range(20, 120);
            for (int k = 0; k < phase_len; k++)
            begin
                code = pick_code(shape, base);
                send_sample(code);
                if (code != GLITCH_CODE)
                    sent++;
            end
        end

        wait_idle();
        if (errors == 0)
            $display("two_pass_dc_and_rms_meter_unit: match");
        else
            $display("two_pass_dc_and_rms_meter_unit: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/dcrms_pkg.sv
rtl/dcrms_engine.sv
rtl/two_pass_dc_and_rms_meter_unit.sv
tb/two_pass_dc_and_rms_meter_checker.sv
tb/two_pass_dc_and_rms_meter_unit_tb.sv
